// ===== hw/rtl/lse_pkg.sv =====
package lse_pkg;

   // Commands carried by an input item
   localparam logic [1:0] CMD_LOAD_POS  = 2'd0;
   localparam logic [1:0] CMD_LOAD_TOPO = 2'd1;
   localparam logic [1:0] CMD_COMPUTE   = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_GRAVITY_WEIGHT = 3'd0;
   localparam logic [2:0] CSR_SPRING_WEIGHT  = 3'd1;
   localparam logic [2:0] CSR_SHEAR_WEIGHT   = 3'd2;
   localparam logic [2:0] CSR_BENDING_WEIGHT = 3'd3;
   localparam logic [2:0] CSR_REST_LENGTH    = 3'd4;
   localparam logic [2:0] CSR_PARTICLE_COUNT = 3'd5;

   localparam int POS_W     = 32;
   localparam int IDX_W     = 10;
   localparam int FLAG_W    = 10;
   localparam int ENERGY_W  = 48;
   localparam int ROOT_W    = 33;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 34;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

// ===== hw/rtl/lse_if.sv =====
interface lse_req_if import lse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   logic [IDX_W-1:0]         particle_index;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic [FLAG_W-1:0]        link_flags;
   logic [IDX_W-1:0]         neighbour_a;
   logic [IDX_W-1:0]         neighbour_b;
   logic [IDX_W-1:0]         neighbour_c;
   logic [IDX_W-1:0]         neighbour_d;

   modport source (output valid, cmd, particle_index, pos_x, pos_y, pos_z, link_flags,
                   neighbour_a, neighbour_b, neighbour_c, neighbour_d, input ready);
   modport sink (input valid, cmd, particle_index, pos_x, pos_y, pos_z, link_flags,
                 neighbour_a, neighbour_b, neighbour_c, neighbour_d, output ready);
endinterface

interface lse_rsp_if import lse_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] energy;
   logic                saturated;

   modport source (output valid, energy, saturated, input ready);
   modport sink (input valid, energy, saturated, output ready);
endinterface

// ===== hw/rtl/lattice_spring_energy_eval_unit.sv =====
// Spring-lattice energy evaluator.
// req_bus (valid/ready) carries one item per command. Load-position and
// load-topology items write their data at particle_index into the position
// and the flag and neighbour memories; they give no result. A compute item
// walks particles 0 .. min(particle_count, MAX_PARTICLES)-1 and returns one
// item on rsp_bus with the saturating Q32.16 energy and a saturation flag.
// A link uses one square root and, unless its length is zero, three
// divisions; an angle pair uses one of each. A parallel pair skips its
// division, and a neighbour index at or above MAX_PARTICLES is wrapped by
// repeated subtraction. The root unit and divider are shared by links and
// angle pairs. The block takes no item while a compute runs.
// csr_* writes a configuration register; write only while idle.
// Reset clears the registers to their defaults and the held link directions;
// the memories are not cleared and must be loaded before use.
// If rsp_bus stalls, the finished energy waits in the output register while
// loads keep flowing; a later compute holds its result until the slot frees.
module lattice_spring_energy_eval_unit import lse_pkg::*; #(
   parameter int MAX_PARTICLES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   lse_req_if.sink           req_bus,
   lse_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_PARTICLES);
   localparam int CW = $clog2(MAX_PARTICLES + 1);
   localparam logic [47:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;
   localparam logic [15:0] UNIT_Q14 = 16'd16384;

   typedef enum logic [4:0] {
      ST_IDLE, ST_P_ADDR, ST_P_LATCH,
      ST_L_SEL, ST_L_MOD, ST_L_ADDR, ST_L_DIFF, ST_L_SQ, ST_L_ACC, ST_L_ROOT,
      ST_L_SPR, ST_L_SPR_ACC, ST_L_DIR, ST_L_DIR_WAIT,
      ST_T_SEL, ST_T_SELV, ST_T_MUL, ST_T_ACC, ST_T_CLAMP, ST_T_SQ,
      ST_T_ROOT_START, ST_T_ROOT, ST_T_DIV,
      ST_W_HI, ST_W_LO, ST_W_ADD, ST_OUT
   } state_type;

   // angle pairs: shear (a,c) (b,c) (b,d) (a,d), then bending (a,b) (d,c)
   function automatic logic [1:0] pair_u(input logic [2:0] p);
      case (p)
         3'd0:    return 2'd0;
         3'd1:    return 2'd1;
         3'd2:    return 2'd1;
         3'd3:    return 2'd0;
         3'd4:    return 2'd0;
         3'd5:    return 2'd3;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] pair_v(input logic [2:0] p);
      case (p)
         3'd0:    return 2'd2;
         3'd1:    return 2'd2;
         3'd2:    return 2'd3;
         3'd3:    return 2'd3;
         3'd4:    return 2'd1;
         3'd5:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [3:0] pair_flag(input logic [2:0] p);
      case (p)
         3'd0:    return 4'd6;
         3'd1:    return 4'd7;
         3'd2:    return 4'd8;
         3'd3:    return 4'd9;
         3'd4:    return 4'd4;
         3'd5:    return 4'd5;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic [15:0] abs16(input logic [15:0] v);
      return v[15] ? (~v + 16'd1) : v;
   endfunction

   state_type state_ff;

   // configuration
   logic [31:0] grav_w_ff, spr_w_ff, shr_w_ff, bnd_w_ff, rest_ff;
   logic [10:0] count_ff;

   // particle memories
   logic [95:0]     pos_mem  [MAX_PARTICLES];
   logic [9:0]      flag_mem [MAX_PARTICLES];
   logic [39:0]     nb_mem   [MAX_PARTICLES];
   logic [95:0]     pos_rd_ff;
   logic [9:0]      flag_rd_ff;
   logic [39:0]     nb_rd_ff;
   logic [AW-1:0]   pos_addr;
   logic [AW-1:0]   wr_addr;
   logic            req_acc, idx_ok, load_pos, load_topo;

   // walk state
   logic [CW-1:0]   i_ff, n_ff;
   logic [2:0]      k_ff, p_ff, g_ff;
   logic [1:0]      j_ff;
   logic [AW-1:0]   nb_idx_ff;
   logic [9:0]      nb_mod_ff;
   logic [31:0]     self_ff [3];
   logic [9:0]      flags_ff;
   logic [9:0]      nbs_ff [4];

   // link datapath
   logic [31:0]     mag_ff [3];
   logic            neg_ff [3];
   logic            big_ff;
   logic [63:0]     sq_sum_ff;
   logic [33:0]     norm_ff;
   logic signed [15:0] held_ff [4][3];

   // angle datapath
   logic signed [15:0] u_ff [3];
   logic signed [15:0] v_ff [3];
   logic            sign_ff;
   logic signed [31:0] c_ff;
   logic [28:0]     ac_ff;
   logic            is_bend_ff;

   // sums and result
   logic [63:0]     grav_ff, spr_ff, shr_ff, bnd_ff;
   logic            sat_ff;
   logic [63:0]     ph_ff;
   logic [49:0]     total_ff;
   logic [47:0]     energy_ff;
   logic            sat_out_ff;
   logic            rsp_valid_ff;

   // shared multiplier
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     mul_ff;

   sqrt_req_type    sqrt_req;
   sqrt_rsp_type    sqrt_rsp;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   // combinational helpers
   logic [31:0]        nb_pos [3];
   logic signed [32:0] diff [3];
   logic [32:0]        dmag [3];
   logic [31:0]        abs_z;
   logic [63:0]        sq_next;
   logic [33:0]        norm_new;
   logic signed [34:0] stretch;
   logic [34:0]        m_c;
   logic signed [31:0] c_cl;
   logic [29:0]        tan_num;
   logic [9:0]         nb_sel;
   logic               nb_wrap;
   logic [15:0]        dir_cap;
   logic [31:0]        wgt;
   logic [63:0]        wsum;
   logic [48:0]        wres;
   logic [49:0]        total_next;

   lse_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   lse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc   = req_bus.valid && req_bus.ready;
   assign idx_ok    = {22'd0, req_bus.particle_index} < 32'(MAX_PARTICLES);
   assign load_pos  = req_acc && (req_bus.cmd == CMD_LOAD_POS) && idx_ok;
   assign load_topo = req_acc && (req_bus.cmd == CMD_LOAD_TOPO) && idx_ok;
   assign wr_addr   = AW'(req_bus.particle_index);
   assign pos_addr  = (state_ff == ST_L_ADDR) ? nb_idx_ff : i_ff[AW-1:0];

   // memories: one write port from loads, registered reads for the walk
   always_ff @(posedge clock) begin
      if (load_pos) begin
         pos_mem[wr_addr] <= {req_bus.pos_x, req_bus.pos_y, req_bus.pos_z};
      end
      if (load_topo) begin
         flag_mem[wr_addr] <= req_bus.link_flags;
         nb_mem[wr_addr]   <= {req_bus.neighbour_d, req_bus.neighbour_c,
                               req_bus.neighbour_b, req_bus.neighbour_a};
      end
      pos_rd_ff  <= pos_mem[pos_addr];
      flag_rd_ff <= flag_mem[i_ff[AW-1:0]];
      nb_rd_ff   <= nb_mem[i_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   always_comb begin
      nb_pos[0] = pos_rd_ff[95:64];
      nb_pos[1] = pos_rd_ff[63:32];
      nb_pos[2] = pos_rd_ff[31:0];
      for (int n = 0; n < 3; n++) begin
         diff[n] = $signed({nb_pos[n][31], nb_pos[n]}) - $signed({self_ff[n][31], self_ff[n]});
         dmag[n] = diff[n][32] ? 33'(-diff[n]) : 33'(diff[n]);
      end
      abs_z    = pos_rd_ff[31] ? (~pos_rd_ff[31:0] + 32'd1) : pos_rd_ff[31:0];
      sq_next  = sq_sum_ff + (big_ff ? (mul_ff >> 2) : mul_ff);
      norm_new = big_ff ? {sqrt_rsp.root, 1'b0} : {1'b0, sqrt_rsp.root};
      stretch  = $signed({1'b0, norm_ff}) - $signed({3'd0, rest_ff});
      m_c      = stretch[34] ? 35'(-stretch) : 35'(stretch);
      if (c_ff > ONE_Q28) begin
         c_cl = ONE_Q28;
      end else if (c_ff < -ONE_Q28) begin
         c_cl = -ONE_Q28;
      end else begin
         c_cl = c_ff;
      end
      tan_num  = is_bend_ff ? 30'(c_ff + ONE_Q28) : {1'b0, ac_ff};
      nb_sel   = nbs_ff[k_ff[1:0]];
      nb_wrap  = {22'd0, nb_sel} >= 32'(MAX_PARTICLES);
      dir_cap  = (div_rsp.quo > 48'(UNIT_Q14)) ? UNIT_Q14 : div_rsp.quo[15:0];
      case (g_ff[1:0])
         2'd0:    begin wgt = grav_w_ff; wsum = grav_ff; end
         2'd1:    begin wgt = spr_w_ff;  wsum = spr_ff;  end
         2'd2:    begin wgt = shr_w_ff;  wsum = shr_ff;  end
         default: begin wgt = bnd_w_ff;  wsum = bnd_ff;  end
      endcase
      wres       = {1'b0, ph_ff[31:0], 16'd0} + 49'(mul_ff >> 16);
      total_next = total_ff + 50'(wres);
   end

   // multiplier operand select
   always_comb begin
      case (state_ff)
         ST_L_SQ: begin
            mul_a = mag_ff[j_ff];
            mul_b = mag_ff[j_ff];
         end
         ST_L_SPR: begin
            mul_a = m_c[31:0];
            mul_b = m_c[31:0];
         end
         ST_T_MUL: begin
            mul_a = {16'd0, abs16(u_ff[j_ff])};
            mul_b = {16'd0, abs16(v_ff[j_ff])};
         end
         ST_T_SQ: begin
            mul_a = {3'd0, ac_ff};
            mul_b = {3'd0, ac_ff};
         end
         ST_W_HI: begin
            mul_a = wgt;
            mul_b = wsum[63:32];
         end
         ST_W_LO: begin
            mul_a = wgt;
            mul_b = wsum[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // root and divider requests
   always_comb begin
      sqrt_req.start    = ((state_ff == ST_L_ACC) && (j_ff == 2'd2))
                          || (state_ff == ST_T_ROOT_START);
      sqrt_req.radicand = (state_ff == ST_L_ACC) ? sq_next
                          : (64'h0100_0000_0000_0000 - mul_ff);
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         ST_L_DIR: begin
            div_req.start = (norm_ff != '0);
            div_req.num   = {2'd0, mag_ff[j_ff], 14'd0};
            div_req.den   = norm_ff;
         end
         ST_T_ROOT: begin
            div_req.start = sqrt_rsp.done && (sqrt_rsp.root != '0);
            div_req.num   = {2'd0, tan_num, 16'd0};
            div_req.den   = DIV_DEN_W'(sqrt_rsp.root);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grav_w_ff    <= '0;
         spr_w_ff     <= '0;
         shr_w_ff     <= '0;
         bnd_w_ff     <= '0;
         rest_ff      <= 32'd65536;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 3; b++) begin
               held_ff[a][b] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRAVITY_WEIGHT: grav_w_ff <= csr_wdata;
               CSR_SPRING_WEIGHT:  spr_w_ff  <= csr_wdata;
               CSR_SHEAR_WEIGHT:   shr_w_ff  <= csr_wdata;
               CSR_BENDING_WEIGHT: bnd_w_ff  <= csr_wdata;
               CSR_REST_LENGTH:    rest_ff   <= csr_wdata;
               CSR_PARTICLE_COUNT: count_ff  <= csr_wdata[10:0];
               default: ;
            endcase
         end

         // drop the result once taken; a waiting compute refills it below
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc && (req_bus.cmd == CMD_COMPUTE)) begin
                  grav_ff  <= '0;
                  spr_ff   <= '0;
                  shr_ff   <= '0;
                  bnd_ff   <= '0;
                  total_ff <= '0;
                  sat_ff   <= 1'b0;
                  i_ff     <= '0;
                  n_ff     <= ({21'd0, count_ff} > 32'(MAX_PARTICLES))
                              ? CW'(MAX_PARTICLES) : CW'(count_ff);
                  for (int a = 0; a < 4; a++) begin
                     for (int b = 0; b < 3; b++) begin
                        held_ff[a][b] <= '0;
                     end
                  end
                  state_ff <= ST_P_ADDR;
               end
            end

            ST_P_ADDR: begin
               if (i_ff == n_ff) begin
                  g_ff     <= '0;
                  state_ff <= ST_W_HI;
               end else begin
                  state_ff <= ST_P_LATCH;
               end
            end

            ST_P_LATCH: begin
               for (int n = 0; n < 3; n++) begin
                  self_ff[n] <= nb_pos[n];
               end
               for (int n = 0; n < 4; n++) begin
                  nbs_ff[n] <= nb_rd_ff[n*10 +: 10];
               end
               flags_ff <= flag_rd_ff;
               grav_ff  <= grav_ff + {32'd0, abs_z};
               k_ff     <= '0;
               state_ff <= ST_L_SEL;
            end

            ST_L_SEL: begin
               if (k_ff == 3'd4) begin
                  p_ff     <= '0;
                  state_ff <= ST_T_SEL;
               end else if (flags_ff[k_ff[1:0]]) begin
                  if (nb_wrap) begin
                     nb_mod_ff <= nb_sel;
                     state_ff  <= ST_L_MOD;
                  end else begin
                     nb_idx_ff <= AW'(nb_sel);
                     state_ff  <= ST_L_ADDR;
                  end
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end

            ST_L_MOD: begin
               // wrap the neighbour index by repeated subtraction
               if ({22'd0, nb_mod_ff} >= 32'(MAX_PARTICLES)) begin
                  nb_mod_ff <= nb_mod_ff - 10'(MAX_PARTICLES);
               end else begin
                  nb_idx_ff <= AW'(nb_mod_ff);
                  state_ff  <= ST_L_ADDR;
               end
            end

            ST_L_ADDR: begin
               state_ff <= ST_L_DIFF;
            end

            ST_L_DIFF: begin
               for (int n = 0; n < 3; n++) begin
                  mag_ff[n] <= dmag[n][31:0];
                  neg_ff[n] <= diff[n][32];
               end
               big_ff    <= dmag[0][31] || dmag[1][31] || dmag[2][31];
               sq_sum_ff <= '0;
               j_ff      <= '0;
               state_ff  <= ST_L_SQ;
            end

            ST_L_SQ: begin
               state_ff <= ST_L_ACC;
            end

            ST_L_ACC: begin
               sq_sum_ff <= sq_next;
               if (j_ff == 2'd2) begin
                  j_ff     <= '0;
                  state_ff <= ST_L_ROOT;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_L_SQ;
               end
            end

            ST_L_ROOT: begin
               if (sqrt_rsp.done) begin
                  norm_ff  <= norm_new;
                  state_ff <= ST_L_SPR;
               end
            end

            ST_L_SPR: begin
               if (m_c[34:32] != 3'd0) begin
                  spr_ff   <= spr_ff + {16'd0, ENERGY_MAX};
                  sat_ff   <= 1'b1;
                  state_ff <= ST_L_DIR;
               end else begin
                  state_ff <= ST_L_SPR_ACC;
               end
            end

            ST_L_SPR_ACC: begin
               spr_ff   <= spr_ff + {16'd0, mul_ff[63:16]};
               state_ff <= ST_L_DIR;
            end

            ST_L_DIR: begin
               if (norm_ff != '0) begin
                  state_ff <= ST_L_DIR_WAIT;
               end else begin
                  // coincident particles: zero direction
                  held_ff[k_ff[1:0]][j_ff] <= '0;
                  if (j_ff == 2'd2) begin
                     j_ff     <= '0;
                     k_ff     <= k_ff + 3'd1;
                     state_ff <= ST_L_SEL;
                  end else begin
                     j_ff <= j_ff + 2'd1;
                  end
               end
            end

            ST_L_DIR_WAIT: begin
               if (div_rsp.done) begin
                  held_ff[k_ff[1:0]][j_ff] <= neg_ff[j_ff] ? (~dir_cap + 16'd1) : dir_cap;
                  if (j_ff == 2'd2) begin
                     j_ff     <= '0;
                     k_ff     <= k_ff + 3'd1;
                     state_ff <= ST_L_SEL;
                  end else begin
                     j_ff     <= j_ff + 2'd1;
                     state_ff <= ST_L_DIR;
                  end
               end
            end

            ST_T_SEL: begin
               if (p_ff == 3'd6) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_P_ADDR;
               end else if (flags_ff[pair_flag(p_ff)]) begin
                  for (int n = 0; n < 3; n++) begin
                     u_ff[n] <= held_ff[pair_u(p_ff)][n];
                  end
                  is_bend_ff <= (p_ff >= 3'd4);
                  state_ff   <= ST_T_SELV;
               end else begin
                  p_ff <= p_ff + 3'd1;
               end
            end

            ST_T_SELV: begin
               for (int n = 0; n < 3; n++) begin
                  v_ff[n] <= held_ff[pair_v(p_ff)][n];
               end
               c_ff     <= '0;
               j_ff     <= '0;
               state_ff <= ST_T_MUL;
            end

            ST_T_MUL: begin
               sign_ff  <= u_ff[j_ff][15] ^ v_ff[j_ff][15];
               state_ff <= ST_T_ACC;
            end

            ST_T_ACC: begin
               if (sign_ff) begin
                  c_ff <= c_ff - $signed({3'd0, mul_ff[28:0]});
               end else begin
                  c_ff <= c_ff + $signed({3'd0, mul_ff[28:0]});
               end
               if (j_ff == 2'd2) begin
                  j_ff     <= '0;
                  state_ff <= ST_T_CLAMP;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_T_MUL;
               end
            end

            ST_T_CLAMP: begin
               c_ff     <= c_cl;
               ac_ff    <= c_cl[31] ? 29'(-c_cl) : c_cl[28:0];
               state_ff <= ST_T_SQ;
            end

            ST_T_SQ: begin
               state_ff <= ST_T_ROOT_START;
            end

            ST_T_ROOT_START: begin
               state_ff <= ST_T_ROOT;
            end

            ST_T_ROOT: begin
               if (sqrt_rsp.done) begin
                  if (sqrt_rsp.root != '0) begin
                     state_ff <= ST_T_DIV;
                  end else begin
                     // parallel pair: tangent saturates unless the numerator is zero
                     if (tan_num != '0) begin
                        sat_ff <= 1'b1;
                        if (is_bend_ff) begin
                           bnd_ff <= bnd_ff + 64'h0000_0000_FFFF_FFFF;
                        end else begin
                           shr_ff <= shr_ff + 64'h0000_0000_FFFF_FFFF;
                        end
                     end
                     p_ff     <= p_ff + 3'd1;
                     state_ff <= ST_T_SEL;
                  end
               end
            end

            ST_T_DIV: begin
               if (div_rsp.done) begin
                  if (div_rsp.quo[47:32] != '0) begin
                     sat_ff <= 1'b1;
                     if (is_bend_ff) begin
                        bnd_ff <= bnd_ff + 64'h0000_0000_FFFF_FFFF;
                     end else begin
                        shr_ff <= shr_ff + 64'h0000_0000_FFFF_FFFF;
                     end
                  end else if (is_bend_ff) begin
                     bnd_ff <= bnd_ff + {32'd0, div_rsp.quo[31:0]};
                  end else begin
                     shr_ff <= shr_ff + {32'd0, div_rsp.quo[31:0]};
                  end
                  p_ff     <= p_ff + 3'd1;
                  state_ff <= ST_T_SEL;
               end
            end

            ST_W_HI: begin
               state_ff <= ST_W_LO;
            end

            ST_W_LO: begin
               ph_ff    <= mul_ff;
               state_ff <= ST_W_ADD;
            end

            ST_W_ADD: begin
               if ((ph_ff[63:32] != '0) || wres[48]) begin
                  sat_ff   <= 1'b1;
                  total_ff <= total_ff + {2'd0, ENERGY_MAX};
               end else begin
                  total_ff <= total_next;
               end
               if (g_ff == 3'd3) begin
                  state_ff <= ST_OUT;
               end else begin
                  g_ff     <= g_ff + 3'd1;
                  state_ff <= ST_W_HI;
               end
            end

            ST_OUT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  if (total_ff[49:48] != 2'd0) begin
                     energy_ff  <= ENERGY_MAX;
                     sat_out_ff <= 1'b1;
                  end else begin
                     energy_ff  <= total_ff[47:0];
                     sat_out_ff <= sat_ff;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.energy    = energy_ff;
   assign rsp_bus.saturated = sat_out_ff;

endmodule

// ===== hw/rtl/lse_isqrt.sv =====
module lse_isqrt import lse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type sqrt_req,
   output sqrt_rsp_type sqrt_rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [63:0] v_ff;
   logic [63:0] r_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = r_ff + bit_ff;

   // one result bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_req.start) begin
            busy_ff <= 1'b1;
            v_ff    <= sqrt_req.radicand;
            r_ff    <= '0;
            bit_ff  <= 64'h4000_0000_0000_0000;
         end else if (busy_ff) begin
            if (v_ff >= trial) begin
               v_ff <= v_ff - trial;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = r_ff[ROOT_W-1:0];

endmodule

// ===== hw/rtl/lse_divider.sv =====
module lse_divider import lse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W+1:0] diff;

   assign shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b0, den_ff};

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W - 1);
            den_ff  <= div_req.den;
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
         end else if (busy_ff) begin
            if (!diff[DIV_DEN_W+1]) begin
               rem_ff <= diff[DIV_DEN_W-1:0];
               quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[DIV_DEN_W-1:0];
               quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule
